// File: sv/trmm_pkg.sv
// ----------------------------------------------------------------------------
// trmm_pkg: shared types and constants for the max/min reflectance block
// Payload structs, the square-root chain state and the widths they follow.
// ----------------------------------------------------------------------------
package trmm_pkg;

  localparam int unsigned PixW  = 8;             // pixel and result width
  localparam int unsigned DiffW = PixW + 1;      // signed pixel difference
  localparam int unsigned SqW   = 2 * PixW;      // one squared difference
  localparam int unsigned RadW  = SqW + 2;       // radicand E = 2*(d1^2 + d2^2)
  localparam int unsigned RootW = RadW / 2;      // one cell per root bit
  localparam int unsigned RemW  = RootW + 1;     // remainder is at most 2*root
  localparam int unsigned CsumW = PixW + 1;      // pixel_a + pixel_c + 1
  localparam int unsigned FrontStages = 2;
  localparam int unsigned LatCycles   = FrontStages + RootW + 1;
  localparam logic [PixW-1:0] PixMax  = '1;

  typedef struct packed {
    logic [PixW-1:0] pixel_a;
    logic [PixW-1:0] pixel_b;
    logic [PixW-1:0] pixel_c;
  } pix_t;

  typedef struct packed {
    logic [PixW-1:0] reflect_max;
    logic [PixW-1:0] reflect_min;
  } res_t;

  // State handed from one root cell to the next
  typedef struct packed {
    logic             vld;
    logic [RadW-1:0]  rad;    // radicand bits still to consume, msb first
    logic [RemW-1:0]  rem;    // running remainder
    logic [RootW-1:0] root;   // partial root
    logic [CsumW-1:0] csum;   // pixel_a + pixel_c + 1, carried along
  } sqrt_st_t;

endpackage

// File: sv/trmm_front.sv
// ----------------------------------------------------------------------------
// trmm_front: radicand front end
// Two stages: pixel differences, then squares summed and doubled.
// ----------------------------------------------------------------------------
module trmm_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                vld_i,
  input  trmm_pkg::pix_t      pix_i,
  output trmm_pkg::sqrt_st_t  st_o
);

  logic                               vld_a_q;
  logic signed [trmm_pkg::DiffW-1:0]  d1_q, d2_q;
  logic        [trmm_pkg::CsumW-1:0]  csum_a_q;

  logic signed [2*trmm_pkg::DiffW-1:0] p1, p2;
  logic        [trmm_pkg::SqW:0]       sq_sum;

  logic                               vld_b_q;
  logic        [trmm_pkg::RadW-1:0]   rad_q;
  logic        [trmm_pkg::CsumW-1:0]  csum_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
    end else begin
      vld_a_q <= vld_i;
      vld_b_q <= vld_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    d1_q     <= $signed({1'b0, pix_i.pixel_a}) - $signed({1'b0, pix_i.pixel_b});
    d2_q     <= $signed({1'b0, pix_i.pixel_b}) - $signed({1'b0, pix_i.pixel_c});
    csum_a_q <= {1'b0, pix_i.pixel_a} + {1'b0, pix_i.pixel_c} + trmm_pkg::CsumW'(1);
  end

  // Squares of 9-bit signed values fit 16 bits unsigned
  assign p1     = (2*trmm_pkg::DiffW)'(d1_q) * (2*trmm_pkg::DiffW)'(d1_q);
  assign p2     = (2*trmm_pkg::DiffW)'(d2_q) * (2*trmm_pkg::DiffW)'(d2_q);
  assign sq_sum = {1'b0, p1[trmm_pkg::SqW-1:0]} + {1'b0, p2[trmm_pkg::SqW-1:0]};

  always_ff @(posedge clk_i) begin
    rad_q    <= {sq_sum, 1'b0};
    csum_b_q <= csum_a_q;
  end

  always_comb begin
    st_o      = '0;
    st_o.vld  = vld_b_q;
    st_o.rad  = rad_q;
    st_o.csum = csum_b_q;
  end

endmodule

// File: sv/trmm_cell.sv
// ----------------------------------------------------------------------------
// trmm_cell: one square-root cell
// Resolve one root bit from the next two radicand bits and pass on.
// ----------------------------------------------------------------------------
module trmm_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  trmm_pkg::sqrt_st_t  st_i,
  output trmm_pkg::sqrt_st_t  st_o
);

  localparam int unsigned AccW = trmm_pkg::RemW + 2;

  logic [AccW-1:0] acc, trial, diff;
  logic            take;

  logic                        vld_q;
  logic [trmm_pkg::RadW-1:0]   rad_q;
  logic [trmm_pkg::RemW-1:0]   rem_q;
  logic [trmm_pkg::RootW-1:0]  root_q;
  logic [trmm_pkg::CsumW-1:0]  csum_q;

  assign acc   = {st_i.rem, st_i.rad[trmm_pkg::RadW-1 -: 2]};
  assign trial = {1'b0, st_i.root, 2'b01};
  assign take  = (acc >= trial);
  assign diff  = acc - trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= st_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= {st_i.rad[trmm_pkg::RadW-3:0], 2'b00};
    rem_q  <= take ? diff[trmm_pkg::RemW-1:0] : acc[trmm_pkg::RemW-1:0];
    root_q <= {st_i.root[trmm_pkg::RootW-2:0], take};
    csum_q <= st_i.csum;
  end

  always_comb begin
    st_o.vld  = vld_q;
    st_o.rad  = rad_q;
    st_o.rem  = rem_q;
    st_o.root = root_q;
    st_o.csum = csum_q;
  end

endmodule

// File: sv/trmm_back.sv
// ----------------------------------------------------------------------------
// trmm_back: result stage
// Round max/min from the root and remainder, clamp, and register.
// ----------------------------------------------------------------------------
module trmm_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  trmm_pkg::sqrt_st_t  st_i,
  output logic                done_o,
  output trmm_pkg::res_t      res_o
);

  logic [trmm_pkg::CsumW:0]   hi_sum;
  logic [trmm_pkg::CsumW-1:0] hi_half;
  logic [trmm_pkg::RootW:0]   root_up;
  logic signed [trmm_pkg::CsumW+1:0] lo_diff;
  logic [trmm_pkg::PixW-1:0]  max_d, min_d;

  logic                       done_q;
  trmm_pkg::res_t             res_q;

  // Ceiling root: bump when the remainder is nonzero
  assign root_up = {1'b0, st_i.root} + (trmm_pkg::RootW+1)'(st_i.rem != '0);
  assign hi_sum  = {1'b0, st_i.csum} + (trmm_pkg::CsumW+1)'(st_i.root);
  assign hi_half = hi_sum[trmm_pkg::CsumW:1];
  assign lo_diff = $signed({2'b00, st_i.csum}) - $signed({1'b0, root_up});

  always_comb begin
    if (hi_half > trmm_pkg::CsumW'(trmm_pkg::PixMax)) begin
      max_d = trmm_pkg::PixMax;
    end else begin
      max_d = hi_half[trmm_pkg::PixW-1:0];
    end
    if (lo_diff[trmm_pkg::CsumW+1]) begin
      min_d = '0;
    end else begin
      min_d = lo_diff[trmm_pkg::PixW:1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= st_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q.reflect_max <= max_d;
    res_q.reflect_min <= min_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// File: sv/ting_reflectance_max_min.sv
// ----------------------------------------------------------------------------
// ting_reflectance_max_min: max/min bireflectance per pixel
// Each start transfer yields one done strobe with its result.
// Throughput: one pixel per cycle; busy is never raised.
// Data flows through 2 front stages, the 9-cell square-root chain
// and 1 result stage. Reset clears only the valid bits along the chain.
// Results show for one cycle on done_o; the receiver cannot stall.
// ----------------------------------------------------------------------------
module ting_reflectance_max_min (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  trmm_pkg::pix_t  pix_i,
  output logic            done_o,
  output trmm_pkg::res_t  res_o
);

  // Chain links: link 0 leaves the front end, link RootW enters the back end
  trmm_pkg::sqrt_st_t chain [trmm_pkg::RootW+1];

  // Every stage advances each cycle, so a new transfer is always taken
  assign busy = 1'b0;

  // Front end: differences and csum = a + c + 1, then E = 2*(d1^2 + d2^2)
  trmm_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (start & ~busy),
    .pix_i  (pix_i),
    .st_o   (chain[0])
  );

  // Root chain: each cell settles one root bit, msb first, by the
  // restoring digit-by-digit method, and hands the remainder onward
  for (genvar gi = 0; gi < trmm_pkg::RootW; gi++) begin : g_cell
    trmm_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .st_i   (chain[gi]),
      .st_o   (chain[gi+1])
    );
  end

  // Result stage: max uses floor root, min uses ceiling root
  trmm_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .st_i   (chain[trmm_pkg::RootW]),
    .done_o (done_o),
    .res_o  (res_o)
  );

endmodule

// File: sv/trmm_checker.sv
// ----------------------------------------------------------------------------
// trmm_checker: port-level checks for the reflectance block
// Watches transfers on the ports and the timing and ordering of results.
// ----------------------------------------------------------------------------
module trmm_checker (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  input  logic            busy,
  input  trmm_pkg::pix_t  pix_i,
  input  logic            done_o,
  input  trmm_pkg::res_t  res_o
);

  // Never hold off a transfer
  a_never_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy)
    else $error("busy raised");

  // Every transfer yields a result after the fixed latency
  a_result_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##(trmm_pkg::LatCycles) done_o)
    else $error("result missing after transfer");

  // No result without a matching transfer
  a_no_spurious : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, trmm_pkg::LatCycles))
    else $error("result without transfer");

  // Maximum never falls below minimum
  a_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (res_o.reflect_max >= res_o.reflect_min))
    else $error("max below min");

  // Equal pixels give max and min equal to that pixel
  a_flat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && pix_i.pixel_a == pix_i.pixel_b
     && pix_i.pixel_b == pix_i.pixel_c)
    |-> ##(trmm_pkg::LatCycles)
    (res_o.reflect_max == $past(pix_i.pixel_a, trmm_pkg::LatCycles)
     && res_o.reflect_min == $past(pix_i.pixel_a, trmm_pkg::LatCycles)))
    else $error("flat pixel result wrong");

endmodule

bind ting_reflectance_max_min trmm_checker u_trmm_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .pix_i  (pix_i),
  .done_o (done_o),
  .res_o  (res_o)
);
